>>> rtl/core/oss_pkg.sv
// Shared types, constants and sizes for the offset-shifted sketch register store.
package oss_pkg;

	localparam int REG_BITS = 8;
	localparam int NUM_REGS = 256;
	localparam int ADDR_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int IDX_W    = 8;
	localparam int VAL_W    = 32;
	localparam int OFS_W    = 32;
	localparam int OUT_W    = 8;

	localparam logic [VAL_W-1:0] RMAX = VAL_W'((64'd1 << REG_BITS) - 64'd1);
	localparam logic [OFS_W-1:0] RESET_OFFSET = OFS_W'(1 - (1 <<< (REG_BITS - 1)));
	localparam logic [OFS_W-1:0] RESET_START  = 32'hFFFF_FF81;

	typedef logic [REG_BITS-1:0] reg_t;

	typedef enum logic [1:0] {
		FN_READ  = 2'd0,
		FN_SET   = 2'd1,
		FN_CLEAR = 2'd2,
		FN_SPARE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		K_READ  = 2'd0,
		K_WRITE = 2'd1,
		K_SHIFT = 2'd2,
		K_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              hit;
		logic [ADDR_W-1:0] addr;
		reg_t              wdata;
		logic [VAL_W-1:0]  excess;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bstat_t;

endpackage

>>> rtl/core/oss_front.sv
// Front end: decodes a request into a command for the sweep engine.
module oss_front import oss_pkg::*; (
	input  logic [1:0]       func,
	input  logic [IDX_W-1:0] index,
	input  logic [VAL_W-1:0] value,
	output cmd_t             cmd
);

	logic over;

	always_comb begin
		over       = value > RMAX;
		cmd.hit    = 32'(index) < NUM_REGS;
		cmd.addr   = ADDR_W'(index);
		cmd.wdata  = REG_BITS'(value);
		cmd.excess = value - RMAX;
		unique case (func_t'(func))
			FN_SET:   cmd.kind = over ? K_SHIFT : K_WRITE;
			FN_CLEAR: cmd.kind = K_CLEAR;
			default:  cmd.kind = K_READ;
		endcase
	end

endmodule

>>> rtl/core/oss_queue.sv
// Two-entry command queue between front end and sweep engine.
module oss_queue import oss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/oss_back.sv
// Back end: sweeps the register array per command, tracks offset and minimum.
module oss_back import oss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  cmd_t             q_cmd,
	output logic             q_pop,
	input  logic [OFS_W-1:0] start_offset,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [OUT_W-1:0] read_value,
	output logic [OFS_W-1:0] offset_now,
	output logic [OUT_W-1:0] min_value,
	output logic             shifted,
	output bstat_t           stat
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SWEEP = 3'b010,
		S_DONE  = 3'b100
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [ADDR_W:0]     cnt_q;
	logic                act_s1;
	logic [ADDR_W-1:0]   addr_s1;
	reg_t                rdata_s1;
	logic                vld_s1;
	reg_t                min_q;
	reg_t                rd_q;
	logic [OFS_W-1:0]    offset_q;
	logic                rsp_valid_q;
	reg_t                mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;

	logic issue;
	logic last_s1;
	logic match_s1;
	logic out_free;
	logic load_out;
	reg_t cur;
	reg_t new_val;

	assign issue    = (state_q == S_SWEEP) && (cnt_q < (ADDR_W+1)'(NUM_REGS));
	assign last_s1  = act_s1 && (addr_s1 == ADDR_W'(NUM_REGS - 1));
	assign match_s1 = cmd_q.hit && (addr_s1 == cmd_q.addr);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign load_out = (state_q == S_DONE) && out_free;
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign rsp_valid = rsp_valid_q;
	assign stat.busy = state_q != S_IDLE;
	assign stat.done = state_q == S_DONE;

	always_comb begin
		cur = vld_s1 ? rdata_s1 : '0;
		case (cmd_q.kind)
			K_CLEAR: new_val = '0;
			K_SHIFT: new_val = (32'(cur) >= cmd_q.excess) ?
				cur - cmd_q.excess[REG_BITS-1:0] : '0;
			default: new_val = cur;
		endcase
		if (match_s1) begin
			if (cmd_q.kind == K_WRITE) begin
				new_val = cmd_q.wdata;
			end else if (cmd_q.kind == K_SHIFT) begin
				new_val = RMAX[REG_BITS-1:0];
			end
		end
	end

	// array read issue and write-back
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[cnt_q[ADDR_W-1:0]];
			vld_s1   <= valid_q[cnt_q[ADDR_W-1:0]];
			addr_s1  <= cnt_q[ADDR_W-1:0];
		end
		if (act_s1) begin
			mem[addr_s1] <= new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			min_q <= '1;
			rd_q  <= '0;
		end else if (act_s1) begin
			if (new_val < min_q) begin
				min_q <= new_val;
			end
			if (match_s1) begin
				rd_q <= new_val;
			end
		end
		if (load_out) begin
			read_value <= OUT_W'(rd_q);
			min_value  <= OUT_W'(min_q);
			offset_now <= offset_q;
			shifted    <= cmd_q.kind == K_SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			act_s1      <= 1'b0;
			valid_q     <= '0;
			offset_q    <= RESET_OFFSET;
			rsp_valid_q <= 1'b0;
		end else begin
			act_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (act_s1) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= '0;
						state_q <= S_SWEEP;
						if (q_cmd.kind == K_CLEAR) begin
							offset_q <= start_offset;
						end else if (q_cmd.kind == K_SHIFT) begin
							offset_q <= offset_q + q_cmd.excess;
						end
					end
				end
				S_SWEEP: begin
					if (last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/offset_shifted_sketch_register_store_unit.sv
// Top level of the offset-shifted sketch register store.
//
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | func, index, value
// rsp     | out       | rsp_valid/rsp_stall | read_value, offset_now, min_value, shifted
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (start_offset)
//
// In the sweep engine, every request walks the whole array once through its single read and write port.
// A two-entry queue lets the front end take requests while the engine is busy.
// Reset is asynchronous; per-entry valid bits make the array read as zero, no clearing pass.
// A stalled response holds its register; the engine waits in its done state meanwhile.
module offset_shifted_sketch_register_store_unit import oss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       func,
	input  logic [IDX_W-1:0] index,
	input  logic [VAL_W-1:0] value,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [OUT_W-1:0] read_value,
	output logic [OFS_W-1:0] offset_now,
	output logic [OUT_W-1:0] min_value,
	output logic             shifted,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [OFS_W-1:0] cfg_data
);

	cmd_t             front_cmd;
	cmd_t             q_cmd;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	logic [OFS_W-1:0] start_q;
	bstat_t           stat;

	assign cfg_ready = 1'b1;
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RESET_START;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	oss_front u_front (
		.func  (func),
		.index (index),
		.value (value),
		.cmd   (front_cmd)
	);

	oss_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (front_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_cmd),
		.empty  (q_empty)
	);

	oss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.start_offset (start_q),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.read_value   (read_value),
		.offset_now   (offset_now),
		.min_value    (min_value),
		.shifted      (shifted),
		.stat         (stat)
	);

	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> stat.busy)
		else $error("engine not busy after taking a command");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(stat.done))
		else $error("response raised without a finished sweep");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && !rsp_stall) |=> (rsp_valid && !stat.done))
		else $error("finished sweep not delivered");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the offset-shifted sketch register store unit.
module tb_top import oss_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OUT_W-1:0] rd;
		logic [OFS_W-1:0] ofs;
		logic [OUT_W-1:0] mn;
		logic             sh;
	} sketch_result_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             req_valid  = 1'b0;
	logic             req_stall;
	logic [1:0]       func       = FN_READ;
	logic [IDX_W-1:0] index      = '0;
	logic [VAL_W-1:0] value      = '0;
	logic             rsp_valid;
	logic             rsp_stall  = 1'b0;
	logic [OUT_W-1:0] read_value;
	logic [OFS_W-1:0] offset_now;
	logic [OUT_W-1:0] min_value;
	logic             shifted;
	logic             cfg_valid  = 1'b0;
	logic             cfg_ready;
	logic [OFS_W-1:0] cfg_data   = '0;

	// shadow state of the store
	reg_t             shadow_regs [NUM_REGS];
	logic [OFS_W-1:0] shadow_offset;
	logic [OFS_W-1:0] shadow_start;
	sketch_result_t   pending_sketch_results [$];
	int               mismatches = 0;
	bit               calm = 1'b0;

	offset_shifted_sketch_register_store_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.index      (index),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.offset_now (offset_now),
		.min_value  (min_value),
		.shifted    (shifted),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 26);
	end

	function automatic sketch_result_t predict_sketch_result(func_t f, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] val);
		sketch_result_t   r;
		logic [VAL_W-1:0] excess;
		reg_t             lowest;
		bit               hit;
		hit  = int'(idx) < NUM_REGS;
		r.sh = 1'b0;
		case (f)
			FN_SET: begin
				if (val > RMAX) begin
					excess = val - RMAX;
					foreach (shadow_regs[j])
						shadow_regs[j] = (VAL_W'(shadow_regs[j]) >= excess) ?
							reg_t'(VAL_W'(shadow_regs[j]) - excess) : '0;
					shadow_offset = shadow_offset + excess;
					r.sh = 1'b1;
					if (hit)
						shadow_regs[idx] = reg_t'(RMAX);
				end else if (hit) begin
					shadow_regs[idx] = reg_t'(val);
				end
			end
			FN_CLEAR: begin
				foreach (shadow_regs[j])
					shadow_regs[j] = '0;
				shadow_offset = shadow_start;
			end
			default: ;
		endcase
		lowest = shadow_regs[0];
		foreach (shadow_regs[j])
			if (shadow_regs[j] < lowest)
				lowest = shadow_regs[j];
		r.rd  = hit ? OUT_W'(shadow_regs[idx]) : '0;
		r.ofs = shadow_offset;
		r.mn  = OUT_W'(lowest);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		sketch_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_sketch_results.size() == 0) begin
				$display("%0t response with none outstanding: read_value %0h offset_now %0h",
					$time, read_value, offset_now);
				mismatches++;
			end else begin
				want = pending_sketch_results.pop_front();
				check_field("read_value", 32'(want.rd), 32'(read_value));
				check_field("offset_now", want.ofs, offset_now);
				check_field("min_value", 32'(want.mn), 32'(min_value));
				check_field("shifted", 32'(want.sh), 32'(shifted));
			end
		end
	end

	// valid stays high across back-to-back transactions, except for random idle gaps inserted while calm is clear
	task automatic send_req(input func_t f, input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		if (!calm && $urandom_range(99) < 26) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 26);
		end
		req_valid <= 1'b1;
		func      <= f;
		index     <= idx;
		value     <= val;
		do @(posedge clk); while (req_stall);
		pending_sketch_results.push_back(predict_sketch_result(f, idx, val));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_sketch_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_offset(input logic [OFS_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_start = v;
	endtask

	task automatic test_reset_state();
		send_req(FN_READ, '0, '0);
		send_req(FN_READ, '1, '1);
		send_req(FN_SPARE, 8'd7, 32'h0000_0010);
		send_req(FN_CLEAR, 8'd3, '0);
	endtask

	task automatic test_set_extremes();
		send_req(FN_SET, '0, '0);
		send_req(FN_SET, '1, RMAX);
		send_req(FN_SET, 8'h80, 32'h0000_00AA);
		send_req(FN_SET, 8'h01, 32'h0000_0055);
		send_req(FN_READ, 8'h80, 32'hFFFF_FFFF);
		send_req(FN_SPARE, 8'h01, 32'h0000_0001);
	endtask

	task automatic test_overflow_shift();
		send_req(FN_SET, 8'd3, RMAX + 1);
		send_req(FN_SET, 8'd4, RMAX + 45);
		send_req(FN_READ, 8'h80, '0);
		send_req(FN_SET, '0, 32'hFFFF_FFFF);
		send_req(FN_SET, 8'd200, 32'h8000_0000);
	endtask

	task automatic test_offset_wrap();
		write_start_offset(32'h7FFF_FFFF);
		send_req(FN_CLEAR, 8'd9, '0);
		send_req(FN_SET, 8'd9, RMAX + 1);
		send_req(FN_READ, 8'd9, '0);
	endtask

	task automatic test_start_offset_extremes();
		write_start_offset(32'h8000_0000);
		send_req(FN_CLEAR, 8'd0, '0);
		send_req(FN_SET, 8'd10, 32'hFFFF_FFFF);
		write_start_offset('0);
		send_req(FN_CLEAR, '1, '0);
	endtask

	// every register loaded at or above a floor, then small shifts mixed with reads and sets
	task automatic test_fill_and_shift();
		int   floor_v;
		int   pick;
		floor_v = $urandom_range(200, 1);
		send_req(FN_CLEAR, IDX_W'($urandom), $urandom);
		for (int i = 0; i < NUM_REGS; i++)
			send_req(FN_SET, IDX_W'(i), VAL_W'($urandom_range(RMAX, floor_v)));
		repeat (16) begin
			pick = $urandom_range(2);
			if (pick == 0)
				send_req(FN_SET, IDX_W'($urandom), RMAX + $urandom_range(floor_v / 4 + 1, 1));
			else if (pick == 1)
				send_req(FN_READ, IDX_W'($urandom), $urandom);
			else
				send_req(FN_SET, IDX_W'($urandom), VAL_W'($urandom_range(RMAX, floor_v)));
		end
	endtask

	task automatic test_random_mix(input int count);
		func_t            f;
		logic [VAL_W-1:0] v;
		int               pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 45)
				f = FN_SET;
			else if (pick < 85)
				f = FN_READ;
			else if (pick < 93)
				f = FN_CLEAR;
			else
				f = FN_SPARE;
			pick = $urandom_range(99);
			if (pick < 55)
				v = VAL_W'($urandom_range(RMAX));
			else if (pick < 80)
				v = RMAX + $urandom_range(64, 1);
			else if (pick < 90)
				v = RMAX + $urandom_range(1024, 1);
			else
				v = $urandom;
			send_req(f, IDX_W'($urandom), v);
		end
	endtask

	initial begin
		foreach (shadow_regs[j])
			shadow_regs[j] = '0;
		shadow_offset = RESET_OFFSET;
		shadow_start  = RESET_START;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_set_extremes();
		test_overflow_shift();
		test_offset_wrap();
		test_start_offset_extremes();

		write_start_offset($urandom);
		test_random_mix(300);
		calm = 1'b1;
		write_start_offset(32'h8000_0000);
		test_fill_and_shift();
		calm = 1'b0;
		write_start_offset(RESET_START);
		test_random_mix(300);
		write_start_offset($urandom);
		test_fill_and_shift();

		drain();
		repeat (600) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
rtl/core/oss_pkg.sv
rtl/core/oss_front.sv
rtl/core/oss_queue.sv
rtl/core/oss_back.sv
rtl/core/offset_shifted_sketch_register_store_unit.sv
sim/tb_top.sv
